@@ design/rtq_pkg.sv @@
`timescale 1ns / 1ps

package rtq_pkg;

    localparam int unsigned ITERATIONS_DEF = 8;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 31;
    localparam int unsigned Q_W            = 32;

    // +-5000.0 in Q16.16
    localparam logic signed [31:0] LAM_LIMIT = 32'sd327680000;

    localparam logic [CFG_IDX_W-1:0] CFG_REG_WEIGHT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WSUM_RECIP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RADIUS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_RHO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = 3'd5;

    localparam logic [CFG_DATA_W-1:0] RST_REG_WEIGHT  = 31'd65536;
    localparam logic [CFG_DATA_W-1:0] RST_SMOOTH      = 31'd65536;
    localparam logic [CFG_DATA_W-1:0] RST_WSUM_RECIP  = 31'd32768;
    localparam logic [CFG_DATA_W-1:0] RST_INV_RADIUS  = 31'd262144;
    localparam logic [CFG_DATA_W-1:0] RST_PENALTY_RHO = 31'd65536;
    localparam logic [CFG_DATA_W-1:0] RST_STEP_SIZE   = 31'd655;

    // Saturate a 33-bit sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v > 33'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -33'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Q16.16 product: round to nearest (ties up), drop 16 bits, saturate.
    function automatic logic signed [31:0] mulq(input logic signed [65:0] p);
        logic signed [65:0] q;
        logic signed [65:0] s;
        q = p + 66'sd32768;
        s = q >>> 16;
        if (s > 66'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (s < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    // With inverted bounds, a value below the lower bound gets the lower bound; any other gets the upper.
    function automatic logic signed [31:0] clampq(input logic signed [31:0] x,
                                                  input logic signed [31:0] lo,
                                                  input logic signed [31:0] hi);
        if (x < lo) begin
            return lo;
        end else if (x > hi) begin
            return hi;
        end
        return x;
    endfunction

endpackage

@@ design/rear_torque_qp_iterative.sv @@
`timescale 1ns / 1ps
// Each of the 6 blend products and 1 + 8*ITERATIONS solver products passes one shared
//   33x33 multiplier in three steps (operand load, multiply, round/saturate/update).
// Requests: o_s_tready is high only in idle; it is low while solving and until the result is loaded.
// Reset (synchronous, active low): configuration registers return to their reset values,
//   multiplier state clears to zero, output request dropped.
module rear_torque_qp_iterative #(
    parameter int unsigned ITERATIONS = rtq_pkg::ITERATIONS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_wr_en,
    input  logic [rtq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rtq_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input request
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // warm_left, warm_right, prior_left, prior_right, force_demand,
    // lower_left, upper_left, lower_right, upper_right (32 bits each)
    input  logic [287:0]                    i_s_tdata,
    // result request
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // torque_left[31:0], torque_right[63:32], residual[94:64], zero pad[95]
    output logic [95:0]                     o_m_tdata
);

    localparam int unsigned IterW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
    localparam logic [IterW-1:0] IterLast = IterW'(ITERATIONS - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} t_state;
    typedef enum logic [3:0] {
        OP_B0, OP_B1, OP_B2, OP_B3, OP_B4, OP_B5,
        OP_I0, OP_I1, OP_I2, OP_I3, OP_I4, OP_I5, OP_I6, OP_I7, OP_I8
    } t_op;

    // configuration
    logic [30:0] r_wreg, r_wsm, r_recip, r_a, r_rho, r_alpha;

    // request fields
    logic signed [31:0] r_wl, r_wr, r_pl, r_pr, r_b, r_lol, r_hil, r_lor, r_hir;

    // solver state
    t_state             r_state;
    t_op                r_op;
    logic [1:0]         r_phase;
    logic [IterW-1:0]   r_iter;
    logic signed [31:0] r_t0, r_bl, r_br, r_tl, r_tr, r_lam, r_viol, r_com, r_gl, r_gr;
    logic signed [31:0] r_multiplier;
    logic signed [32:0] r_opa, r_opb;
    logic signed [65:0] r_prod;
    logic               r_out_valid;
    logic [95:0]        r_out_data;

    logic signed [32:0] n_opa, n_opb;
    logic signed [31:0] m, h, tsum, dl, dr, lam_clamped;
    logic signed [32:0] viol_ext, viol_abs;
    logic [30:0]        residual;
    logic               accept, can_emit;

    assign accept   = i_s_tvalid && o_s_tready;
    assign can_emit = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign h    = rtq_pkg::sat33({2'b00, r_wreg} + {2'b00, r_wsm});
    assign tsum = rtq_pkg::sat33({r_tl[31], r_tl} + {r_tr[31], r_tr});
    assign dl   = rtq_pkg::sat33({r_tl[31], r_tl} - {r_bl[31], r_bl});
    assign dr   = rtq_pkg::sat33({r_tr[31], r_tr} - {r_br[31], r_br});
    assign m    = rtq_pkg::mulq(r_prod);

    // Operand selection for the shared multiplier.
    always_comb begin
        n_opa = '0;
        n_opb = '0;
        case (r_op)
            OP_B0: begin n_opa = {2'b00, r_wreg};  n_opb = {r_wl[31], r_wl}; end
            OP_B1: begin n_opa = {2'b00, r_wsm};   n_opb = {r_pl[31], r_pl}; end
            OP_B2: begin n_opa = {r_t0[31], r_t0}; n_opb = {2'b00, r_recip}; end
            OP_B3: begin n_opa = {2'b00, r_wreg};  n_opb = {r_wr[31], r_wr}; end
            OP_B4: begin n_opa = {2'b00, r_wsm};   n_opb = {r_pr[31], r_pr}; end
            OP_B5: begin n_opa = {r_t0[31], r_t0}; n_opb = {2'b00, r_recip}; end
            OP_I0, OP_I7: begin n_opa = {2'b00, r_a}; n_opb = {tsum[31], tsum}; end
            OP_I1, OP_I8: begin n_opa = {2'b00, r_rho}; n_opb = {r_viol[31], r_viol}; end
            OP_I2: begin n_opa = {2'b00, r_a};     n_opb = {r_t0[31], r_t0}; end
            OP_I3: begin n_opa = {h[31], h};       n_opb = {dl[31], dl}; end
            OP_I4: begin n_opa = {h[31], h};       n_opb = {dr[31], dr}; end
            OP_I5: begin n_opa = {2'b00, r_alpha}; n_opb = {r_gl[31], r_gl}; end
            OP_I6: begin n_opa = {2'b00, r_alpha}; n_opb = {r_gr[31], r_gr}; end
            default: begin n_opa = '0; n_opb = '0; end
        endcase
    end

    // Final residual |viol|, saturating full scale; multiplier clamp to +-5000.
    always_comb begin
        viol_ext = {r_viol[31], r_viol};
        viol_abs = r_viol[31] ? -viol_ext : viol_ext;
        residual = (viol_abs > 33'sd2147483647) ? 31'h7FFF_FFFF : viol_abs[30:0];
        lam_clamped = rtq_pkg::clampq(r_lam, -rtq_pkg::LAM_LIMIT, rtq_pkg::LAM_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_op         <= OP_B0;
            r_phase      <= '0;
            r_iter       <= '0;
            r_out_valid  <= 1'b0;
            r_multiplier <= '0;
            r_wreg       <= rtq_pkg::RST_REG_WEIGHT;
            r_wsm        <= rtq_pkg::RST_SMOOTH;
            r_recip      <= rtq_pkg::RST_WSUM_RECIP;
            r_a          <= rtq_pkg::RST_INV_RADIUS;
            r_rho        <= rtq_pkg::RST_PENALTY_RHO;
            r_alpha      <= rtq_pkg::RST_STEP_SIZE;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    rtq_pkg::CFG_REG_WEIGHT:  r_wreg  <= i_cfg_data;
                    rtq_pkg::CFG_SMOOTH:      r_wsm   <= i_cfg_data;
                    rtq_pkg::CFG_WSUM_RECIP:  r_recip <= i_cfg_data;
                    rtq_pkg::CFG_INV_RADIUS:  r_a     <= i_cfg_data;
                    rtq_pkg::CFG_PENALTY_RHO: r_rho   <= i_cfg_data;
                    rtq_pkg::CFG_STEP_SIZE:   r_alpha <= i_cfg_data;
                    default: ;
                endcase
            end

            // Drop the taken result; a finished solve reloads it below instead.
            if (r_out_valid && i_m_tready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        // Latch the request and start from the clamped warm start.
                        r_wl  <= i_s_tdata[31:0];
                        r_wr  <= i_s_tdata[63:32];
                        r_pl  <= i_s_tdata[95:64];
                        r_pr  <= i_s_tdata[127:96];
                        r_b   <= i_s_tdata[159:128];
                        r_lol <= i_s_tdata[191:160];
                        r_hil <= i_s_tdata[223:192];
                        r_lor <= i_s_tdata[255:224];
                        r_hir <= i_s_tdata[287:256];
                        r_tl  <= rtq_pkg::clampq(i_s_tdata[31:0], i_s_tdata[191:160],
                                                 i_s_tdata[223:192]);
                        r_tr  <= rtq_pkg::clampq(i_s_tdata[63:32], i_s_tdata[255:224],
                                                 i_s_tdata[287:256]);
                        r_lam   <= r_multiplier;
                        r_op    <= OP_B0;
                        r_phase <= '0;
                        r_iter  <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    case (r_phase)
                        2'd0: begin
                            r_opa   <= n_opa;
                            r_opb   <= n_opb;
                            r_phase <= 2'd1;
                        end
                        2'd1: begin
                            r_prod  <= r_opa * r_opb;
                            r_phase <= 2'd2;
                        end
                        default: begin
                            // Round the product, update the target register, advance.
                            // The end-of-step violation is the next step's start.
                            r_phase <= 2'd0;
                            r_op    <= (r_op == OP_I8) ? OP_I1 : t_op'(r_op + 4'd1);
                            case (r_op)
                                OP_B0, OP_B3: r_t0 <= m;
                                OP_B1, OP_B4: r_t0 <= rtq_pkg::sat33({r_t0[31], r_t0} + {m[31], m});
                                OP_B2: r_bl <= m;
                                OP_B5: r_br <= m;
                                OP_I0, OP_I7: r_viol <= rtq_pkg::sat33({m[31], m} - {r_b[31], r_b});
                                OP_I1: r_t0 <= rtq_pkg::sat33({r_lam[31], r_lam} + {m[31], m});
                                OP_I2: r_com <= m;
                                OP_I3: r_gl <= rtq_pkg::sat33({m[31], m} + {r_com[31], r_com});
                                OP_I4: r_gr <= rtq_pkg::sat33({m[31], m} + {r_com[31], r_com});
                                OP_I5: r_tl <= rtq_pkg::clampq(
                                    rtq_pkg::sat33({r_tl[31], r_tl} - {m[31], m}), r_lol, r_hil);
                                OP_I6: r_tr <= rtq_pkg::clampq(
                                    rtq_pkg::sat33({r_tr[31], r_tr} - {m[31], m}), r_lor, r_hir);
                                OP_I8: begin
                                    r_lam <= rtq_pkg::sat33({r_lam[31], r_lam} + {m[31], m});
                                    if (r_iter == IterLast) begin
                                        r_state <= ST_DONE;
                                    end else begin
                                        r_iter <= r_iter + 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    endcase
                end
                ST_DONE: begin
                    // Hold until the output register is free.
                    if (can_emit) begin
                        r_out_valid  <= 1'b1;
                        r_out_data   <= {1'b0, residual, r_tr, r_tl};
                        r_multiplier <= lam_clamped;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // The stored multiplier never leaves its clamp range.
    a_lam_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_multiplier <= rtq_pkg::LAM_LIMIT) && (r_multiplier >= -rtq_pkg::LAM_LIMIT))
        else $error("multiplier out of range");

    // An accepted request always starts the solver.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_RUN) && (r_op == OP_B0))
        else $error("solver did not start");

    // The multiplier state only moves when a result is loaded.
    a_lam_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_multiplier != $past(r_multiplier)) |-> o_m_tvalid)
        else $error("multiplier changed without a result");

    // A result is never loaded over one still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !i_m_tready) |=> $stable(r_out_data))
        else $error("pending result overwritten");

endmodule
